@@ rtl/spd_pkg.sv @@
`timescale 1ns / 1ps
package spd_pkg;

    // Request kinds carried in s_tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_POWER = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_FREQUENCY = 2'd0;
    localparam logic [1:0] CFG_FLOOR     = 2'd1;
    localparam logic [1:0] CFG_CEILING   = 2'd2;
    localparam logic [1:0] CFG_INVERT    = 2'd3;

    localparam int FREQ_W    = 19;
    localparam int DUTY_W    = 17;
    localparam int CFG_DW    = 19;
    localparam int POWER_W   = 18;
    localparam int DIVISOR_W = 25;  // frequency shifted left by up to six

    localparam logic [FREQ_W-1:0] FREQ_MIN = 19'd8;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 19'd320000;
    localparam logic [DUTY_W-1:0] DUTY_ONE = 17'd65536;

    // Prescaler selection codes
    localparam logic [2:0] DIV_STOPPED = 3'd0;
    localparam logic [2:0] DIV_1       = 3'd1;
    localparam logic [2:0] DIV_2       = 3'd2;
    localparam logic [2:0] DIV_4       = 3'd3;
    localparam logic [2:0] DIV_8       = 3'd4;
    localparam logic [2:0] DIV_64      = 3'd5;

    // Output modes
    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_PWM  = 2'd2;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency_hz;
        logic [DUTY_W-1:0] duty_floor;
        logic [DUTY_W-1:0] duty_ceiling;
        logic              invert_output;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic capture;
        logic div_step;
        logic top_load;
        logic num0;
        logic num1;
        logic prd0;
        logic prd1;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic stopped;
    } stat_t;

    typedef struct packed {
        logic        clock_stopped;
        logic [15:0] compare_value;
        logic        direction_pin;
        logic        tool_enable;
        logic        pwm_pin;
    } result_t;

    function automatic logic [2:0] div_shift(input logic [2:0] sel);
        logic [2:0] s;
        unique case (sel)
            DIV_2:   s = 3'd1;
            DIV_4:   s = 3'd2;
            DIV_8:   s = 3'd3;
            DIV_64:  s = 3'd6;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] div_ratio(input logic [2:0] sel);
        return 7'd1 << div_shift(sel);
    endfunction

endpackage

@@ rtl/spindle_pwm_driver.sv @@
`timescale 1ns / 1ps
// Clock tick and ignored requests: result registered the cycle after the transfer, one per cycle
// while the consumer keeps up. Power update: ST_DIV (one-bit-a-cycle period divider, CW the bit width
// of CLOCK_HZ, 25 at 32 MHz), NUM0, NUM1, PRD0, PRD1, COMMIT. No input during an update.
// Reset (rst_n low, asynchronous): timer stopped, pin low, enable and direction 0, config at
// reset values (frequency 8 Hz, duties 0, no inversion), no result pending.
module spindle_pwm_driver
#(
    parameter int CLOCK_HZ    = 32000000,
    parameter int TIMER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [17:0] power_level, [18] estop_active, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] pwm_pin, [1] tool_enable, [2] direction_pin,
                                   // [18:3] compare_value, [19] clock_stopped, rest zero
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [18:0] cfg_wdata
);

    spd_pkg::cfg_t    cfg_reg;
    spd_pkg::cmd_t    cmd;
    spd_pkg::stat_t   stat;
    spd_pkg::result_t result;

    logic        load_result;
    logic        out_free;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [23:0] m_tdata_reg;

    // Configuration: saturate on write and hold; power updates read it, inversion acts at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frequency_hz  <= spd_pkg::FREQ_MIN;
            cfg_reg.duty_floor    <= '0;
            cfg_reg.duty_ceiling  <= '0;
            cfg_reg.invert_output <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spd_pkg::CFG_FREQUENCY:
                begin
                    if (cfg_wdata < spd_pkg::FREQ_MIN)
                    begin
                        cfg_reg.frequency_hz <= spd_pkg::FREQ_MIN;
                    end
                    else if (cfg_wdata > spd_pkg::FREQ_MAX)
                    begin
                        cfg_reg.frequency_hz <= spd_pkg::FREQ_MAX;
                    end
                    else
                    begin
                        cfg_reg.frequency_hz <= cfg_wdata;
                    end
                end
                spd_pkg::CFG_FLOOR:
                begin
                    if (cfg_wdata > 19'(spd_pkg::DUTY_ONE))
                    begin
                        cfg_reg.duty_floor <= spd_pkg::DUTY_ONE;
                    end
                    else
                    begin
                        cfg_reg.duty_floor <= cfg_wdata[16:0];
                    end
                end
                spd_pkg::CFG_CEILING:
                begin
                    if (cfg_wdata > 19'(spd_pkg::DUTY_ONE))
                    begin
                        cfg_reg.duty_ceiling <= spd_pkg::DUTY_ONE;
                    end
                    else
                    begin
                        cfg_reg.duty_ceiling <= cfg_wdata[16:0];
                    end
                end
                spd_pkg::CFG_INVERT:
                begin
                    cfg_reg.invert_output <= cfg_wdata[0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // The result register may take a new transfer in the cycle it is drained
    assign out_free = !m_tvalid_reg || m_tready;

    spd_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .req_type    (s_tuser),
        .out_free    (out_free),
        .stat        (stat),
        .s_tready    (s_tready),
        .load_result (load_result),
        .cmd         (cmd)
    );

    spd_datapath
    #(
        .CLOCK_HZ    (CLOCK_HZ),
        .TIMER_WIDTH (TIMER_WIDTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .power_level  (s_tdata[17:0]),
        .estop_active (s_tdata[18]),
        .stat         (stat),
        .result       (result)
    );

    // Hold the result until the consumer takes the transfer
    always_comb
    begin
        if (load_result)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            m_tdata_reg <= {4'b0000, result};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/spd_ctrl.sv @@
`timescale 1ns / 1ps
module spd_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic [1:0]     req_type,
    input  logic           out_free,
    input  spd_pkg::stat_t stat,
    output logic           s_tready,
    output logic           load_result,
    output spd_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_NUM0   = 3'd2;
    localparam logic [2:0] ST_NUM1   = 3'd3;
    localparam logic [2:0] ST_PRD0   = 3'd4;
    localparam logic [2:0] ST_PRD1   = 3'd5;
    localparam logic [2:0] ST_COMMIT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        load_result = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
                if (s_tvalid && out_free)
                begin
                    unique case (req_type)
                        spd_pkg::REQ_TICK:
                        begin
                            cmd.tick    = 1'b1;
                            load_result = 1'b1;
                        end
                        spd_pkg::REQ_POWER:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_DIV;
                        end
                        default:
                        begin
                            load_result = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                cmd.div_step = !stat.stopped;
                if (stat.stopped || stat.div_last)
                begin
                    state_next = ST_NUM0;
                end
            end
            ST_NUM0:
            begin
                cmd.num0     = 1'b1;
                cmd.top_load = !stat.stopped;
                state_next   = ST_NUM1;
            end
            ST_NUM1:
            begin
                cmd.num1   = 1'b1;
                state_next = ST_PRD0;
            end
            ST_PRD0:
            begin
                cmd.prd0   = 1'b1;
                state_next = ST_PRD1;
            end
            ST_PRD1:
            begin
                cmd.prd1   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit  = 1'b1;
                load_result = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/spd_datapath.sv @@
`timescale 1ns / 1ps
module spd_datapath
#(
    parameter int CLOCK_HZ    = 32000000,
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  spd_pkg::cfg_t                      cfg,
    input  spd_pkg::cmd_t                      cmd,
    input  logic signed [spd_pkg::POWER_W-1:0] power_level,
    input  logic                               estop_active,
    output spd_pkg::stat_t                     stat,
    output spd_pkg::result_t                   result
);

    localparam int TW    = TIMER_WIDTH;
    localparam int CW    = $clog2(CLOCK_HZ + 1);
    localparam int CNT_W = $clog2(CW);
    localparam int DW    = spd_pkg::DIVISOR_W;
    localparam int AW    = (TW > spd_pkg::DUTY_W) ? TW : spd_pkg::DUTY_W;
    localparam int BW    = spd_pkg::DUTY_W;
    localparam int PW    = AW + BW;
    localparam int NW    = 33;
    localparam int ACW   = TW + NW;
    localparam int BASE  = CLOCK_HZ >> TIMER_WIDTH;
    localparam logic [63:0] TOP_MAX_W = (64'd1 << TIMER_WIDTH) - 64'd1;

    // Timer state
    logic [TW-1:0] count_reg,   count_next;
    logic [5:0]    prescale_reg, prescale_next;
    logic [TW-1:0] top_reg,     top_next;
    logic [TW-1:0] compare_reg, compare_next;
    logic [2:0]    sel_reg,     sel_next;
    logic [1:0]    mode_reg,    mode_next;
    logic          enable_reg,  enable_next;
    logic          dir_reg,     dir_next;

    // Update working registers
    logic [16:0]    mag_reg;
    logic           neg_reg;
    logic           estop_reg;
    logic [CW-1:0]  div_q_reg;
    logic [DW-1:0]  div_rem_reg;
    logic [DW-1:0]  divisor_reg;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [NW-1:0]  num_reg;
    logic [ACW-1:0] acc_reg;

    logic [2:0]    sel_new;
    logic [18:0]   mag_wide;
    logic [16:0]   mag_sat;
    logic [DW:0]   div_shifted;
    logic [DW:0]   div_diff;
    logic [TW-1:0] top_sat;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic [TW-1:0] cmp_val;
    logic [6:0]    pre_inc;
    logic          level;

    // Pick the smallest prescaler with ratio times frequency >= BASE
    always_comb
    begin
        sel_new = spd_pkg::DIV_STOPPED;
        for (int s = 5; s >= 1; s--)
        begin
            if (DW'(BASE) <= (DW'(cfg.frequency_hz) << spd_pkg::div_shift(3'(s))))
            begin
                sel_new = 3'(s);
            end
        end
    end

    // Magnitude of the power, saturated to full scale
    always_comb
    begin
        if (power_level[spd_pkg::POWER_W-1])
        begin
            mag_wide = 19'h40000 - {1'b0, power_level};
        end
        else
        begin
            mag_wide = {1'b0, power_level};
        end
        if (mag_wide > 19'(spd_pkg::DUTY_ONE))
        begin
            mag_sat = spd_pkg::DUTY_ONE;
        end
        else
        begin
            mag_sat = mag_wide[16:0];
        end
    end

    // One quotient bit a cycle
    assign div_shifted = {div_rem_reg, div_q_reg[CW-1]};
    assign div_diff    = div_shifted - {1'b0, divisor_reg};

    always_comb
    begin
        if (64'(div_q_reg) > TOP_MAX_W)
        begin
            top_sat = '1;
        end
        else
        begin
            top_sat = TW'(div_q_reg);
        end
    end

    // Shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.num0)
        begin
            mul_a = AW'(mag_reg);
            mul_b = cfg.duty_ceiling;
        end
        else if (cmd.num1)
        begin
            mul_a = AW'(cfg.duty_floor);
            mul_b = spd_pkg::DUTY_ONE - mag_reg;
        end
        else if (cmd.prd0)
        begin
            mul_a = AW'(top_reg);
            mul_b = BW'(num_reg[15:0]);
        end
        else if (cmd.prd1)
        begin
            mul_a = AW'(top_reg);
            mul_b = num_reg[32:16];
        end
    end

    assign mul_p   = mul_a * mul_b;
    // Zero power gives a zero compare whatever the duty floor
    assign cmp_val = (mag_reg == '0) ? '0 : acc_reg[TW+31:32];
    assign pre_inc = {1'b0, prescale_reg} + 7'd1;

    always_comb
    begin
        count_next    = count_reg;
        prescale_next = prescale_reg;
        top_next      = top_reg;
        compare_next  = compare_reg;
        sel_next      = sel_reg;
        mode_next     = mode_reg;
        enable_next   = enable_reg;
        dir_next      = dir_reg;

        if (cmd.tick && (sel_reg != spd_pkg::DIV_STOPPED))
        begin
            if (pre_inc >= spd_pkg::div_ratio(sel_reg))
            begin
                prescale_next = '0;
                if (count_reg == top_reg)
                begin
                    count_next = '0;
                end
                else
                begin
                    count_next = count_reg + TW'(1);
                end
            end
            else
            begin
                prescale_next = pre_inc[5:0];
            end
        end

        if (cmd.capture)
        begin
            sel_next = sel_new;
        end

        if (cmd.top_load)
        begin
            top_next = top_sat;
        end

        if (cmd.commit)
        begin
            if (estop_reg || (cmp_val == '0))
            begin
                mode_next   = spd_pkg::MODE_LOW;
                enable_next = 1'b0;
            end
            else if (cmp_val == TW'(TOP_MAX_W))
            begin
                mode_next   = spd_pkg::MODE_HIGH;
                enable_next = 1'b1;
            end
            else
            begin
                mode_next    = spd_pkg::MODE_PWM;
                enable_next  = 1'b1;
                compare_next = cmp_val;
            end
            if (cmp_val != '0)
            begin
                dir_next = neg_reg;
            end
        end
    end

    always_comb
    begin
        unique case (mode_next)
            spd_pkg::MODE_HIGH: level = 1'b1;
            spd_pkg::MODE_PWM:  level = (count_next < compare_next);
            default:            level = 1'b0;
        endcase
        result.pwm_pin       = level ^ cfg.invert_output;
        result.tool_enable   = enable_next;
        result.direction_pin = dir_next;
        result.compare_value = 16'(compare_next);
        result.clock_stopped = (sel_next == spd_pkg::DIV_STOPPED);
    end

    assign stat.div_last = (div_cnt_reg == '0);
    assign stat.stopped  = (sel_reg == spd_pkg::DIV_STOPPED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            prescale_reg <= '0;
            top_reg      <= '0;
            compare_reg  <= '0;
            sel_reg      <= spd_pkg::DIV_STOPPED;
            mode_reg     <= spd_pkg::MODE_LOW;
            enable_reg   <= 1'b0;
            dir_reg      <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            prescale_reg <= prescale_next;
            top_reg      <= top_next;
            compare_reg  <= compare_next;
            sel_reg      <= sel_next;
            mode_reg     <= mode_next;
            enable_reg   <= enable_next;
            dir_reg      <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mag_reg     <= mag_sat;
            neg_reg     <= power_level[spd_pkg::POWER_W-1];
            estop_reg   <= estop_active;
            div_q_reg   <= CW'(CLOCK_HZ);
            div_rem_reg <= '0;
            divisor_reg <= DW'(cfg.frequency_hz) << spd_pkg::div_shift(sel_new);
            div_cnt_reg <= CNT_W'(CW - 1);
        end
        else if (cmd.div_step)
        begin
            if (!div_diff[DW])
            begin
                div_rem_reg <= div_diff[DW-1:0];
                div_q_reg   <= {div_q_reg[CW-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_shifted[DW-1:0];
                div_q_reg   <= {div_q_reg[CW-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end

        if (cmd.num0)
        begin
            num_reg <= NW'(mul_p);
        end
        else if (cmd.num1)
        begin
            num_reg <= num_reg + NW'(mul_p);
        end

        if (cmd.prd0)
        begin
            acc_reg <= ACW'(mul_p);
        end
        else if (cmd.prd1)
        begin
            acc_reg <= acc_reg + (ACW'(mul_p) << 16);
        end
    end

endmodule

@@ dv/spd_checker.sv @@
`timescale 1ns / 1ps
module spd_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,        // [17:0] power_level, [18] estop_active
    input  logic [1:0]  s_tuser,        // [1:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,        // [0] pin, [1] enable, [2] direction,
                                        // [18:3] compare, [19] clock_stopped
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [18:0] cfg_wdata,
    output int          mismatch_count,
    output int          outstanding
);

    localparam longint unsigned CLK_HZ    = 64'd32000000;
    localparam longint unsigned TOP_MAX   = 64'd65535;
    localparam longint unsigned TICK_BASE = CLK_HZ >> 16;
    localparam longint unsigned FULL_NUM  = 64'd1 << 32;

    // Shadow configuration
    logic [spd_pkg::FREQ_W-1:0] freq_hz;
    logic [spd_pkg::DUTY_W-1:0] floor_duty;
    logic [spd_pkg::DUTY_W-1:0] ceil_duty;
    logic                       invert;

    // Shadow timer and output stage
    logic [15:0] counter;
    logic [15:0] period;
    logic [15:0] compare;
    logic [5:0]  prescale;
    logic [2:0]  divider;
    logic [1:0]  mode;
    logic        enable;
    logic        reverse;

    spd_pkg::result_t pin_states [$];

    function automatic longint unsigned prescale_ratio(input logic [2:0] sel);
        case (sel)
            spd_pkg::DIV_1:  return 1;
            spd_pkg::DIV_2:  return 2;
            spd_pkg::DIV_4:  return 4;
            spd_pkg::DIV_8:  return 8;
            spd_pkg::DIV_64: return 64;
            default:         return 0;
        endcase
    endfunction

    // Smallest prescaler whose tick span reaches the timer range wins
    task automatic pick_prescaler();
        longint unsigned span;
        longint unsigned quotient;
        divider = spd_pkg::DIV_STOPPED;
        for (int sel = int'(spd_pkg::DIV_1); sel <= int'(spd_pkg::DIV_64); sel++)
        begin
            span = prescale_ratio(3'(sel)) * freq_hz;
            if (divider == spd_pkg::DIV_STOPPED && span >= TICK_BASE)
            begin
                quotient = CLK_HZ / span;
                period   = (quotient > TOP_MAX) ? 16'hFFFF : quotient[15:0];
                divider  = 3'(sel);
            end
        end
    endtask

    function automatic logic [15:0] duty_compare(input logic [17:0] raw);
        logic [17:0]     magnitude;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned scaled;
        magnitude = raw[17] ? ~raw + 18'd1 : raw;
        mag = magnitude;
        if (mag > spd_pkg::DUTY_ONE)
            mag = spd_pkg::DUTY_ONE;
        if (mag == 0)
            return 16'd0;
        if (mag == spd_pkg::DUTY_ONE && ceil_duty == spd_pkg::DUTY_ONE)
            num = FULL_NUM;
        else
            num = mag * ceil_duty + longint'(floor_duty) * (spd_pkg::DUTY_ONE - mag);
        scaled = (longint'(period) * num) >> 32;
        return scaled[15:0];
    endfunction

    task automatic power_request(input logic [17:0] raw, input logic stop);
        logic [15:0] target;
        pick_prescaler();
        target = duty_compare(raw);
        if (stop || target == 16'd0)
        begin
            mode   = spd_pkg::MODE_LOW;
            enable = 1'b0;
        end
        else if (target == 16'hFFFF)
        begin
            mode   = spd_pkg::MODE_HIGH;
            enable = 1'b1;
        end
        else
        begin
            mode    = spd_pkg::MODE_PWM;
            enable  = 1'b1;
            compare = target;
        end
        if (target != 16'd0)
            reverse = raw[17];
    endtask

    task automatic tick_request();
        if (divider != spd_pkg::DIV_STOPPED)
        begin
            if (prescale + 1 >= prescale_ratio(divider))
            begin
                prescale = '0;
                counter  = (counter == period) ? 16'd0 : counter + 16'd1;
            end
            else
                prescale = prescale + 6'd1;
        end
    endtask

    function automatic spd_pkg::result_t present_state();
        spd_pkg::result_t r;
        logic             level;
        case (mode)
            spd_pkg::MODE_HIGH: level = 1'b1;
            spd_pkg::MODE_PWM:  level = counter < compare;
            default:            level = 1'b0;
        endcase
        r.pwm_pin       = level ^ invert;
        r.tool_enable   = enable;
        r.direction_pin = reverse;
        r.compare_value = compare;
        r.clock_stopped = divider == spd_pkg::DIV_STOPPED;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        spd_pkg::result_t seen;
        spd_pkg::result_t due;
        if (!rst_n)
        begin
            freq_hz        = spd_pkg::FREQ_MIN;
            floor_duty     = '0;
            ceil_duty      = '0;
            invert         = 1'b0;
            counter        = '0;
            period         = '0;
            compare        = '0;
            prescale       = '0;
            divider        = spd_pkg::DIV_STOPPED;
            mode           = spd_pkg::MODE_LOW;
            enable         = 1'b0;
            reverse        = 1'b0;
            mismatch_count = 0;
            pin_states.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    spd_pkg::CFG_FREQUENCY:
                        freq_hz = (cfg_wdata < spd_pkg::FREQ_MIN) ? spd_pkg::FREQ_MIN :
                                  (cfg_wdata > spd_pkg::FREQ_MAX) ? spd_pkg::FREQ_MAX
                                                                  : cfg_wdata;
                    spd_pkg::CFG_FLOOR:
                        floor_duty = (cfg_wdata > spd_pkg::DUTY_ONE) ? spd_pkg::DUTY_ONE
                                                                     : cfg_wdata[16:0];
                    spd_pkg::CFG_CEILING:
                        ceil_duty = (cfg_wdata > spd_pkg::DUTY_ONE) ? spd_pkg::DUTY_ONE
                                                                    : cfg_wdata[16:0];
                    default:
                        invert = cfg_wdata[0];
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    spd_pkg::REQ_TICK:  tick_request();
                    spd_pkg::REQ_POWER: power_request(s_tdata[17:0], s_tdata[18]);
                    default:            ;
                endcase
                pin_states.push_back(present_state());
            end

            if (m_tvalid && m_tready)
            begin
                seen = spd_pkg::result_t'(m_tdata[19:0]);
                if (pin_states.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: result %h expected none, got one", $time, m_tdata);
                end
                else
                begin
                    due = pin_states.pop_front();
                    check_field("pwm_pin", due.pwm_pin, seen.pwm_pin);
                    check_field("tool_enable", due.tool_enable, seen.tool_enable);
                    check_field("direction_pin", due.direction_pin, seen.direction_pin);
                    check_field("compare_value", due.compare_value, seen.compare_value);
                    check_field("clock_stopped", due.clock_stopped, seen.clock_stopped);
                end
            end
        end
        outstanding = pin_states.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

    // Request kinds the block drops without touching its state
    localparam logic [1:0] REQ_SKIP_A = 2'd2;
    localparam logic [1:0] REQ_SKIP_B = 2'd3;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 206;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 40;   // outlasts a power update
    localparam int RUN_LIMIT_NS    = 3000000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;     // [17:0] power_level, [18] estop_active, rest zero
    logic [1:0]  s_tuser   = '0;     // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // [0] pwm_pin, [1] tool_enable, [2] direction_pin,
                                     // [18:3] compare_value, [19] clock_stopped
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [18:0] cfg_wdata = '0;

    // Idle percentages of the two sides, changed per phase
    int sender_pct = 0;
    int stall_pct  = 0;

    int mismatch_count;
    int outstanding;

    spindle_pwm_driver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    spd_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side: drop tready at random according to the phase's stall rate
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // Present one request and hold it until a transfer happens. Valid stays high
    // on return so that a following request does not lower and raise it in one step.
    task automatic send_item(input logic [1:0] kind, input logic [17:0] level,
                             input logic stop);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, stop, level};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Hold the input side quiet for a random number of cycles
    task automatic idle_gap();
        while ($urandom_range(0, 99) < sender_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [18:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
    endtask

    // Reprogram all four registers once the block has gone idle
    task automatic apply_setting(input logic [18:0] freq, input logic [18:0] lo,
                                 input logic [18:0] hi, input logic [18:0] inv);
        drain();
        write_reg(spd_pkg::CFG_FREQUENCY, freq);
        write_reg(spd_pkg::CFG_FLOOR, lo);
        write_reg(spd_pkg::CFG_CEILING, hi);
        write_reg(spd_pkg::CFG_INVERT, inv);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_phase(input int phase);
        logic [18:0] freq;
        freq = ($urandom_range(0, 3) == 0) ? 19'($urandom)
                                           : 19'($urandom_range(60000, 320000));
        case (phase)
            // short period, full span of duty
            0: apply_setting(19'd320000, 19'd0, 19'd65536, 19'd0);
            // frequency below the floor and an inverted duty span, prescaler 64
            1: apply_setting(19'd0, 19'd65536, 19'd0, 19'd1);
            // frequency and ceiling writes above their range saturate
            2: apply_setting(19'h7FFFF, 19'd20000, 19'h1FFFF, 19'd0);
            3: apply_setting(19'd150000, 19'd1000, 19'd60000, 19'd1);
            // prescaler 8 with the period clipped to the timer maximum
            4: apply_setting(19'd61, 19'd0, 19'd65536, 19'd0);
            // prescaler 2, constant duty at full scale
            5: apply_setting(19'd300, 19'd65536, 19'd65536, 19'd1);
            default:
                apply_setting(freq, 19'($urandom_range(0, 131071)),
                              19'($urandom_range(0, 65536)), 19'($urandom_range(0, 1)));
        endcase
    endtask

    // Mostly ticks between the odd power update, with a few dropped kinds
    task automatic random_item(output logic [1:0] kind, output logic [17:0] level,
                               output logic stop);
        int unsigned pick;
        int          signed_level;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            kind = spd_pkg::REQ_TICK;
        else if (pick < 94)
            kind = spd_pkg::REQ_POWER;
        else
            kind = pick[0] ? REQ_SKIP_B : REQ_SKIP_A;

        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 6))
                    0:       level = 18'h00000;
                    1:       level = 18'h10000;   // full forward
                    2:       level = 18'h30000;   // full reverse
                    3:       level = 18'h20000;   // most negative code
                    4:       level = 18'h1FFFF;   // most positive code
                    5:       level = 18'h00001;
                    default: level = 18'h3FFFF;
                endcase
            1:
                level = 18'($urandom);
            default:
            begin
                signed_level = int'($urandom_range(0, 131072)) - 65536;
                level = signed_level[17:0];
            end
        endcase
        stop = ($urandom_range(0, 7) == 0);
    endtask

    initial
    begin : stimulus
        int          counted;
        logic [1:0]  kind;
        logic [17:0] level;
        logic        stop;

        // Hold reset low from time zero, release it away from the rising edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: timer stopped until the first power update,
        // dropped kinds leave everything alone, zero duty span gives compare 0
        send_item(spd_pkg::REQ_TICK, 18'h3FFFF, 1'b1);
        send_item(REQ_SKIP_A, 18'h10000, 1'b0);
        send_item(REQ_SKIP_B, 18'h2AAAA, 1'b1);
        send_item(spd_pkg::REQ_POWER, 18'h10000, 1'b0);
        send_item(spd_pkg::REQ_TICK, 18'h00000, 1'b0);

        // Period saturates at the timer maximum: full power forces the pin high
        apply_setting(19'd488, 19'd0, 19'd65536, 19'd0);
        send_item(spd_pkg::REQ_POWER, 18'h10000, 1'b0);
        send_item(spd_pkg::REQ_TICK, 18'h00000, 1'b0);
        send_item(spd_pkg::REQ_POWER, 18'h20000, 1'b0);   // saturated magnitude, reverse
        send_item(spd_pkg::REQ_POWER, 18'h3FFFF, 1'b0);   // compare truncates to zero
        send_item(spd_pkg::REQ_POWER, 18'h00000, 1'b0);
        send_item(spd_pkg::REQ_POWER, 18'h08000, 1'b1);   // estop, direction still follows

        // Short period with inversion: tick the counter in PWM mode
        apply_setting(19'd320000, 19'd0, 19'd65536, 19'd1);
        send_item(spd_pkg::REQ_POWER, 18'h08000, 1'b0);
        repeat (6) send_item(spd_pkg::REQ_TICK, 18'h00000, 1'b0);
        send_item(spd_pkg::REQ_POWER, 18'h30000, 1'b0);
        repeat (3) send_item(spd_pkg::REQ_TICK, 18'h00000, 1'b0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            program_phase(phase);
            // none, sender idle, receiver stalling, then both lightly
            case (phase % 4)
                0:       begin sender_pct <= 0;  stall_pct <= 0;  end
                1:       begin sender_pct <= 81; stall_pct <= 0;  end
                2:       begin sender_pct <= 0;  stall_pct <= 81; end
                default: begin sender_pct <= 14; stall_pct <= 14; end
            endcase
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                random_item(kind, level, stop);
                if ($urandom_range(0, 149) == 0)
                    drain();
                idle_gap();
                send_item(kind, level, stop);
                counted++;
            end
        end

        // Wait for the last results, bounded, then let the block settle
        s_tvalid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && outstanding != 0; n++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("spindle_pwm_driver regression: pass");
        else
        begin
            if (outstanding != 0)
                $display("%0t ns: %0d expected results never arrived", $time, outstanding);
            $display("spindle_pwm_driver regression: fail");
        end
        $finish;
    end

    // Hard stop for a hung handshake
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("spindle_pwm_driver regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/spd_pkg.sv
rtl/spd_ctrl.sv
rtl/spd_datapath.sv
rtl/spindle_pwm_driver.sv
dv/spd_checker.sv
dv/tb_top.sv
